// ===== sv/i2cmbe_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
package i2cmbe_pkg;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  localparam logic [15:0] PHASE_TICKS_RST = 16'd5;

  localparam logic [2:0] FUNC_NONE   = 3'd0;
  localparam logic [2:0] FUNC_START  = 3'd1;
  localparam logic [2:0] FUNC_STOP   = 3'd2;
  localparam logic [2:0] FUNC_WRITE  = 3'd3;
  localparam logic [2:0] FUNC_RD_ACK = 3'd4;
  localparam logic [2:0] FUNC_RD_NAK = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] wr_byte;
    logic       sda_line;
  } cmd_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_byte;
    logic       ack_ok;
  } result_t;

endpackage

// ===== sv/i2c_master_byte_engine_core.sv =====
// I2C master byte engine: one input item per tick, one result item per input item.
// Each input item is one bus timing tick; every accepted item yields exactly one result
// holding the SCL/SDA drive, busy and done flags, last read byte and last ack status.
// Sustained rate is one item per clock while the result queue has room: the phase
// sequencer advances one tick per accepted item. A four-entry command queue and a
// two-entry result queue, both registered, decouple both sides.
// cfg_ready is always high; write phase_ticks only while both queues are empty.
module i2c_master_byte_engine_core
  import i2cmbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_wr_byte,
  input  logic        in_sda_line,
  output logic        empty,
  input  logic        pop,
  output logic        out_scl,
  output logic        out_sda,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_rd_byte,
  output logic        out_ack_ok
);

  logic      q_valid;
  logic      q_pop;
  cmd_item_t q_item;
  result_t   res;

  i2cmbe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_func     (in_func),
    .in_wr_byte  (in_wr_byte),
    .in_sda_line (in_sda_line),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  i2cmbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign out_scl      = res.scl;
  assign out_sda      = res.sda;
  assign out_busy_res = res.busy_res;
  assign out_done_res = res.done_res;
  assign out_rd_byte  = res.rd_byte;
  assign out_ack_ok   = res.ack_ok;

endmodule

// ===== sv/i2cmbe_front.sv =====
// Front end: accepts tick items, classifies the command code and queues them.
module i2cmbe_front
  import i2cmbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [2:0] in_func,
  input  logic [7:0] in_wr_byte,
  input  logic       in_sda_line,
  output logic       q_valid,
  output cmd_item_t  q_item,
  input  logic       q_pop
);

  cmd_item_t            mem_r [CQ_DEPTH];
  logic [CQ_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CQ_AW:0]       cnt_r, cnt_nxt;
  logic                 do_push, do_pop;
  cmd_item_t            item_in;

  always_comb begin
    item_in.wr_byte  = in_wr_byte;
    item_in.sda_line = in_sda_line;
    unique case (in_func) inside
      FUNC_START, FUNC_STOP, FUNC_WRITE, FUNC_RD_ACK, FUNC_RD_NAK: item_in.op = in_func;
      default: item_in.op = FUNC_NONE;
    endcase
  end

  assign full    = (cnt_r == (CQ_AW+1)'(CQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (CQ_AW+1)'(do_push) - (CQ_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ===== sv/i2cmbe_back.sv =====
// Back end: bus phase sequencer, phase_ticks register and result queue.
module i2cmbe_back
  import i2cmbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        q_valid,
  input  cmd_item_t   q_item,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output result_t     res
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ST1    = 4'd1;
  localparam logic [3:0] S_ST2    = 4'd2;
  localparam logic [3:0] S_SP1    = 4'd3;
  localparam logic [3:0] S_SP2    = 4'd4;
  localparam logic [3:0] S_SP3    = 4'd5;
  localparam logic [3:0] S_WR_LO  = 4'd6;
  localparam logic [3:0] S_WR_HI  = 4'd7;
  localparam logic [3:0] S_WA_LO  = 4'd8;
  localparam logic [3:0] S_WA_HI  = 4'd9;
  localparam logic [3:0] S_WA_END = 4'd10;
  localparam logic [3:0] S_RD_LO  = 4'd11;
  localparam logic [3:0] S_RD_HI  = 4'd12;
  localparam logic [3:0] S_RA_LO  = 4'd13;
  localparam logic [3:0] S_RA_HI  = 4'd14;
  localparam logic [3:0] S_RA_END = 4'd15;

  logic [15:0] phase_ticks_r;
  logic [3:0]  state_r, state_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic [7:0]  rd_byte_r, rd_byte_nxt;
  logic        ack_r, ack_nxt;
  logic        fin;
  logic        step_en;
  logic [15:0] load_val;
  logic [3:0]  bit_inc;
  result_t     res_nxt;

  result_t          oq_mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr_r, oq_rd_r;
  logic [OQ_AW:0]   oq_cnt_r, oq_cnt_nxt;
  logic             oq_space, oq_pop;

  assign cfg_ready = 1'b1;

  assign oq_space = (oq_cnt_r != (OQ_AW+1)'(OQ_DEPTH));
  assign step_en  = q_valid && oq_space;
  assign q_pop    = step_en;
  assign empty    = (oq_cnt_r == '0);
  assign oq_pop   = pop && !empty;
  assign res      = oq_mem_r[oq_rd_r];

  assign load_val = (phase_ticks_r == 16'd0) ? 16'd1 : phase_ticks_r;
  assign bit_inc  = bit_cnt_r + 4'd1;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    delay_nxt   = delay_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    rd_byte_nxt = rd_byte_r;
    ack_nxt     = ack_r;
    fin         = 1'b0;
    if (step_en) begin
      if (state_r == S_IDLE) begin
        case (q_item.op) inside
          FUNC_START: begin
            op_nxt = q_item.op; bit_cnt_nxt = 4'd0;
            sda_nxt = 1'b1; scl_nxt = 1'b1;
            state_nxt = S_ST1; delay_nxt = load_val;
          end
          FUNC_STOP: begin
            op_nxt = q_item.op; bit_cnt_nxt = 4'd0;
            scl_nxt = 1'b0; sda_nxt = 1'b0;
            state_nxt = S_SP1; delay_nxt = load_val;
          end
          FUNC_WRITE: begin
            op_nxt = q_item.op; bit_cnt_nxt = 4'd0;
            shift_nxt = q_item.wr_byte; sda_nxt = q_item.wr_byte[7];
            state_nxt = S_WR_LO; delay_nxt = load_val;
          end
          FUNC_RD_ACK, FUNC_RD_NAK: begin
            op_nxt = q_item.op; bit_cnt_nxt = 4'd0;
            shift_nxt = 8'd0; sda_nxt = 1'b1;
            state_nxt = S_RD_LO; delay_nxt = load_val;
          end
          default: ;
        endcase
      end else if (delay_r > 16'd1) begin
        delay_nxt = delay_r - 16'd1;
      end else begin
        unique case (state_r)
          S_ST1: begin sda_nxt = 1'b0; state_nxt = S_ST2; delay_nxt = load_val; end
          S_ST2: begin scl_nxt = 1'b0; fin = 1'b1; end
          S_SP1: begin scl_nxt = 1'b1; state_nxt = S_SP2; delay_nxt = load_val; end
          S_SP2: begin sda_nxt = 1'b1; state_nxt = S_SP3; delay_nxt = load_val; end
          S_SP3: fin = 1'b1;
          S_WR_LO: begin scl_nxt = 1'b1; state_nxt = S_WR_HI; delay_nxt = load_val; end
          S_WR_HI: begin
            scl_nxt     = 1'b0;
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_cnt_nxt = bit_inc;
            delay_nxt   = load_val;
            if (bit_inc < 4'd8) begin
              sda_nxt = shift_r[6]; state_nxt = S_WR_LO;
            end else begin
              sda_nxt = 1'b1; state_nxt = S_WA_LO;
            end
          end
          S_WA_LO: begin scl_nxt = 1'b1; state_nxt = S_WA_HI; delay_nxt = load_val; end
          S_WA_HI: begin
            ack_nxt = !q_item.sda_line; scl_nxt = 1'b0;
            state_nxt = S_WA_END; delay_nxt = load_val;
          end
          S_WA_END: fin = 1'b1;
          S_RD_LO: begin scl_nxt = 1'b1; state_nxt = S_RD_HI; delay_nxt = load_val; end
          S_RD_HI: begin
            shift_nxt   = {shift_r[6:0], q_item.sda_line};
            scl_nxt     = 1'b0;
            bit_cnt_nxt = bit_inc;
            delay_nxt   = load_val;
            if (bit_inc < 4'd8) begin
              state_nxt = S_RD_LO;
            end else begin
              sda_nxt = (op_r != FUNC_RD_ACK); state_nxt = S_RA_LO;
            end
          end
          S_RA_LO: begin scl_nxt = 1'b1; state_nxt = S_RA_HI; delay_nxt = load_val; end
          S_RA_HI: begin scl_nxt = 1'b0; state_nxt = S_RA_END; delay_nxt = load_val; end
          S_RA_END: begin rd_byte_nxt = shift_r; fin = 1'b1; end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          state_nxt = S_IDLE;
          delay_nxt = 16'd0;
        end
      end
    end
  end

  always_comb begin
    res_nxt.scl      = scl_nxt;
    res_nxt.sda      = sda_nxt;
    res_nxt.busy_res = (state_nxt != S_IDLE);
    res_nxt.done_res = fin;
    res_nxt.rd_byte  = rd_byte_nxt;
    res_nxt.ack_ok   = ack_nxt;
    oq_cnt_nxt       = oq_cnt_r + (OQ_AW+1)'(step_en) - (OQ_AW+1)'(oq_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
      state_r       <= S_IDLE;
      op_r          <= FUNC_NONE;
      delay_r       <= 16'd0;
      bit_cnt_r     <= 4'd0;
      shift_r       <= 8'd0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      rd_byte_r     <= 8'd0;
      ack_r         <= 1'b0;
      oq_wr_r       <= '0;
      oq_rd_r       <= '0;
      oq_cnt_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        phase_ticks_r <= cfg_data;
      end
      state_r   <= state_nxt;
      op_r      <= op_nxt;
      delay_r   <= delay_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      rd_byte_r <= rd_byte_nxt;
      ack_r     <= ack_nxt;
      oq_wr_r   <= step_en ? oq_wr_r + 1'b1 : oq_wr_r;
      oq_rd_r   <= oq_pop ? oq_rd_r + 1'b1 : oq_rd_r;
      oq_cnt_r  <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      oq_mem_r[oq_wr_r] <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |-> !(res_nxt.done_res && res_nxt.busy_res))
    else $error("done and busy both set in one item");

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= (OQ_AW+1)'(OQ_DEPTH))
    else $error("result queue count out of range");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(state_r) && $stable(delay_r))
    else $error("sequencer moved without an item");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'd8)
    else $error("bit counter out of range");
`endif

endmodule
